>>> design/picb_pkg.sv
package picb_pkg;

  localparam int DATA_W     = 32;
  localparam int COL_W      = 4;
  localparam int CFG_W      = 5;
  localparam int CNT_W      = 7;
  localparam int IN_TDATA_W = 40;

  localparam logic [CNT_W-1:0] MIN_COUNT   = 7'd3;
  localparam logic [CNT_W-1:0] COUNT_BIAS  = 7'd2;
  localparam logic [CFG_W-1:0] COUNT_RESET = 5'd3;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_INIT,
    OP_MID,
    OP_KU,
    OP_G,
    OP_POW,
    OP_LO,
    OP_HI,
    OP_CMP
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MID,
    ST_KU,
    ST_G,
    ST_POW,
    ST_LO,
    ST_HI,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic in_ready;
    logic load_out;
  } ctrl_t;

endpackage

>>> design/polynomial_inverse_cdf_bisection.sv
// Inverse CDF solver: finds u in [0,1) with u^k * ((k+1) - k*u) = x by bisection.
// Input stream s_axis: one word carries the sample x (Q0.32) and the column j.
// The exponent is k = count - 2 - j, where count is final_count clamped to
// 3..MAX_FINAL; final_count is written through cfg_we_i / cfg_wdata_i. The user
// must write it only while idle; the block does not enforce this. Output stream
// m_axis: one word per input word, the last bisection midpoint (Q0.32). Columns
// without a positive exponent give root 0. One shared 32x32 multiplier runs
// every level: one multiply for k*u, k-1 for the power, two for the final
// product, plus midpoint, setup and compare steps. A column without exponent
// goes straight from accept to the done state; the next word is accepted only
// once the result is loaded into the output register.
// s_axis_tready is high only while the solver is idle; a new word is taken
// while the previous result still waits in the output register.
// If m_axis_tready stays low, the next result waits in the solver until the
// output register is free.
// Reset clears m_axis_tvalid, returns the solver to idle and sets final_count to 3.
module polynomial_inverse_cdf_bisection #(
  parameter int FRAC_BITS = 32,
  parameter int MAX_FINAL = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [picb_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] sample, [35:32] column, [39:36] zero
  input  logic [picb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] root
  output logic [picb_pkg::DATA_W-1:0]       m_axis_tdata
);
  import picb_pkg::*;

  localparam int KW = $clog2(MAX_FINAL);
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_FINAL);

  logic [CFG_W-1:0]  final_count_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] root_q;

  ctrl_t             ctrl;
  logic [DATA_W-1:0] sample;
  logic [COL_W-1:0]  column;
  logic [CNT_W-1:0]  count, k_full;
  logic [KW-1:0]     k;
  logic              no_exp, start, out_free;
  logic [DATA_W-1:0] root;

  assign sample = s_axis_tdata[DATA_W-1:0];
  assign column = s_axis_tdata[DATA_W+COL_W-1:DATA_W];

  always_comb begin
    count = CNT_W'(final_count_q);
    if (count < MIN_COUNT) begin
      count = MIN_COUNT;
    end else if (count > MAX_COUNT) begin
      count = MAX_COUNT;
    end
  end

  assign no_exp   = (CNT_W'(column) + COUNT_BIAS) >= count;
  assign k_full   = count - COUNT_BIAS - CNT_W'(column);
  assign k        = k_full[KW-1:0];
  assign start    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  picb_ctrl #(
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .no_exp_i   (no_exp),
    .k_i        (k),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  picb_datapath #(
    .KW (KW)
  ) u_datapath (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (sample),
    .k_i      (k),
    .root_o   (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_count_q <= COUNT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        final_count_q <= cfg_wdata_i;
      end
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      root_q <= root;
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = root_q;

endmodule

>>> design/picb_ctrl.sv
module picb_ctrl #(
  parameter int FRAC_BITS = 32,
  parameter int KW        = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              no_exp_i,
  input  logic [KW-1:0]     k_i,
  input  logic              out_free_i,
  output picb_pkg::ctrl_t   ctrl_o
);
  import picb_pkg::*;

  localparam int LW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam logic [LW-1:0] LAST_LVL = LW'(FRAC_BITS - 1);

  state_e        state_q, state_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] pow_q, pow_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lvl_q   <= '0;
      k_q     <= '0;
      pow_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      k_q     <= k_d;
      pow_q   <= pow_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    lvl_d           = lvl_q;
    k_d             = k_q;
    pow_d           = pow_q;
    ctrl_o.op       = OP_IDLE;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (start_i) begin
          ctrl_o.op = OP_INIT;
          k_d       = k_i;
          lvl_d     = '0;
          state_d   = no_exp_i ? ST_DONE : ST_MID;
        end
      end
      ST_MID: begin
        ctrl_o.op = OP_MID;
        pow_d     = k_q - KW'(1);
        state_d   = ST_KU;
      end
      ST_KU: begin
        ctrl_o.op = OP_KU;
        state_d   = ST_G;
      end
      ST_G: begin
        ctrl_o.op = OP_G;
        state_d   = (pow_q == '0) ? ST_LO : ST_POW;
      end
      ST_POW: begin
        ctrl_o.op = OP_POW;
        pow_d     = pow_q - KW'(1);
        if (pow_q == KW'(1)) begin
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        ctrl_o.op = OP_LO;
        state_d   = ST_HI;
      end
      ST_HI: begin
        ctrl_o.op = OP_HI;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        ctrl_o.op = OP_CMP;
        if (lvl_q == LAST_LVL) begin
          state_d = ST_DONE;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = ST_MID;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/picb_datapath.sv
module picb_datapath #(
  parameter int KW = 4
) (
  input  logic                          clk_i,
  input  picb_pkg::ctrl_t               ctrl_i,
  input  logic [picb_pkg::DATA_W-1:0]   sample_i,
  input  logic [KW-1:0]                 k_i,
  output logic [picb_pkg::DATA_W-1:0]   root_o
);
  import picb_pkg::*;

  localparam int G_W = DATA_W + KW;
  localparam int F_W = DATA_W + KW + 1;

  logic [DATA_W-1:0]   x_q, lo_q, mid_q, p_q, acc_q;
  logic [DATA_W:0]     hi_q;
  logic [KW-1:0]       k_q;
  logic [G_W-1:0]      kmid_q, g_q;
  logic [F_W-1:0]      f_q;

  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     mid_sum;
  logic [G_W-1:0]      g_d;

  // shared multiplier
  always_comb begin
    mul_a = p_q;
    mul_b = mid_q;
    case (ctrl_i.op)
      OP_KU: begin
        mul_a = mid_q;
        mul_b = DATA_W'(k_q);
      end
      OP_LO: mul_b = g_q[DATA_W-1:0];
      OP_HI: mul_b = DATA_W'(g_q[G_W-1:DATA_W]);
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign mid_sum = {1'b0, lo_q} + hi_q;
  assign g_d     = {k_q + KW'(1), {DATA_W{1'b0}}} - kmid_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_INIT: begin
        x_q   <= sample_i;
        k_q   <= k_i;
        lo_q  <= '0;
        hi_q  <= {1'b1, {DATA_W{1'b0}}};
        mid_q <= '0;
      end
      OP_MID: begin
        mid_q <= mid_sum[DATA_W:1];
        p_q   <= mid_sum[DATA_W:1];
      end
      OP_KU:  kmid_q <= prod[G_W-1:0];
      OP_G:   g_q    <= g_d;
      OP_POW: p_q    <= prod[2*DATA_W-1:DATA_W];
      OP_LO:  acc_q  <= prod[2*DATA_W-1:DATA_W];
      OP_HI:  f_q    <= F_W'(prod[G_W-1:0]) + F_W'(acc_q);
      OP_CMP: begin
        if (F_W'(x_q) <= f_q) begin
          hi_q <= {1'b0, mid_q};
        end else begin
          lo_q <= mid_q;
        end
      end
      default: ;
    endcase
  end

  assign root_o = mid_q;

endmodule
